### rtl/inub_pkg.sv
`default_nettype none
package inub_pkg;

    localparam int RegW    = 13;
    localparam int CfgIdxW = 2;
    localparam int PixW    = 32;
    localparam int IdxW    = 24;

    localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = CfgIdxW'(1);

    localparam logic [RegW-1:0] SCREEN_W_RESET = RegW'(1920);
    localparam logic [RegW-1:0] SCREEN_H_RESET = RegW'(1080);

    localparam int SRC_WIDTH_DEF  = 320;
    localparam int SRC_HEIGHT_DEF = 200;
    localparam int MAX_SCALE_DEF  = 8;
    localparam int MAX_SCREEN_DEF = 4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_EMIT
    } inub_state_t;

    typedef struct packed {
        logic accept;
        logic row_init;
        logic emit;
    } inub_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_write;
    } inub_status_t;

endpackage
`default_nettype wire

### rtl/inub_pix_if.sv
`default_nettype none
interface inub_pix_if import inub_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PixW-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

### rtl/inub_wr_if.sv
`default_nettype none
interface inub_wr_if import inub_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IdxW-1:0] dest_index;
    logic [PixW-1:0] dest_pixel;
    logic            write_valid;
    logic            last_of_block;
    logic            last_of_frame;

    modport source (output valid, output dest_index, output dest_pixel, output write_valid,
                    output last_of_block, output last_of_frame, input ready);
    modport sink   (input valid, input dest_index, input dest_pixel, input write_valid,
                    input last_of_block, input last_of_frame, output ready);
endinterface
`default_nettype wire

### rtl/integer_nearest_upscale_blitter.sv
`default_nettype none
// channel  | dir | handshake     | payload
// pix      | in  | valid / ready | pixel_value
// wr       | out | valid / ready | dest_index, dest_pixel, write_valid,
//          |     |               | last_of_block, last_of_frame
// cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One request runs through accept, row address multiply, then one write per
// cycle out of the write counters while the output is free (scale*scale writes).
// Scale, then offsets, are rederived after reset and after each width or height
// register write; requests are held off meanwhile.
// A stalled write holds the output register and the write counters.
module integer_nearest_upscale_blitter import inub_pkg::*; #(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int MAX_SCALE  = MAX_SCALE_DEF,
    parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    inub_pix_if.sink                pix,
    inub_wr_if.source               wr,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [RegW-1:0]    cfg_data
);
    localparam int ScaleW = $clog2(MAX_SCALE + 1);

    logic [RegW-1:0]   eff_w, eff_h, offset_col, offset_row;
    logic [ScaleW-1:0] scale;
    logic              cfg_busy;
    inub_cmd_t         cmd;
    inub_status_t      status;

    inub_cfg #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .MAX_SCALE  (MAX_SCALE),
        .MAX_SCREEN (MAX_SCREEN)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .scale      (scale),
        .offset_col (offset_col),
        .offset_row (offset_row),
        .busy       (cfg_busy)
    );

    inub_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .cfg_busy (cfg_busy),
        .status   (status),
        .in_ready (pix.ready),
        .cmd      (cmd)
    );

    inub_dp #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .MAX_SCALE  (MAX_SCALE),
        .MAX_SCREEN (MAX_SCREEN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .pixel_value   (pix.pixel_value),
        .eff_w         (eff_w),
        .eff_h         (eff_h),
        .scale         (scale),
        .offset_col    (offset_col),
        .offset_row    (offset_row),
        .out_ready     (wr.ready),
        .out_valid     (wr.valid),
        .dest_index    (wr.dest_index),
        .dest_pixel    (wr.dest_pixel),
        .write_valid   (wr.write_valid),
        .last_of_block (wr.last_of_block),
        .last_of_frame (wr.last_of_frame)
    );

endmodule
`default_nettype wire

### rtl/inub_cfg.sv
`default_nettype none
module inub_cfg import inub_pkg::*; #(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int MAX_SCALE  = MAX_SCALE_DEF,
    parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [CfgIdxW-1:0]           cfg_index,
    input  wire logic [RegW-1:0]              cfg_data,
    output logic [RegW-1:0]                   eff_w,
    output logic [RegW-1:0]                   eff_h,
    output logic [$clog2(MAX_SCALE+1)-1:0]    scale,
    output logic [RegW-1:0]                   offset_col,
    output logic [RegW-1:0]                   offset_row,
    output logic                              busy
);
    localparam int ScaleW = $clog2(MAX_SCALE + 1);

    logic [RegW-1:0]   width_reg, height_reg;
    logic [ScaleW-1:0] scale_reg, scale_next;
    logic [RegW-1:0]   off_col_reg, off_col_next, off_row_reg, off_row_next;
    logic              scale_pend_reg, off_pend_reg;

    function automatic logic [RegW-1:0] eff_dim(input logic [RegW-1:0] v);
        if (v == '0)
            return RegW'(1);
        else if (int'(v) > MAX_SCREEN)
            return RegW'(MAX_SCREEN);
        else
            return v;
    endfunction

    assign eff_w = eff_dim(width_reg);
    assign eff_h = eff_dim(height_reg);

    // scale: largest k up to MAX_SCALE with both dimensions fitting, floor 1
    always_comb
    begin
        scale_next = ScaleW'(1);
        for (int k = 1; k <= MAX_SCALE; k++)
        begin
            if ((k * SRC_WIDTH <= int'(eff_w)) && (k * SRC_HEIGHT <= int'(eff_h)))
                scale_next = ScaleW'(k);
        end
    end

    always_comb
    begin
        int img_w;
        int img_h;
        img_w = SRC_WIDTH * int'(scale_reg);
        img_h = SRC_HEIGHT * int'(scale_reg);
        off_col_next = (int'(eff_w) > img_w) ? RegW'((int'(eff_w) - img_w) >> 1) : '0;
        off_row_next = (int'(eff_h) > img_h) ? RegW'((int'(eff_h) - img_h) >> 1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= SCREEN_W_RESET;
            height_reg     <= SCREEN_H_RESET;
            scale_pend_reg <= 1'b1;
            off_pend_reg   <= 1'b0;
            scale_reg      <= ScaleW'(1);
            off_col_reg    <= '0;
            off_row_reg    <= '0;
        end
        else
        begin
            off_pend_reg   <= scale_pend_reg;
            scale_pend_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SCREEN_WIDTH:
                    begin
                        width_reg      <= cfg_data;
                        scale_pend_reg <= 1'b1;
                    end
                    CFG_SCREEN_HEIGHT:
                    begin
                        height_reg     <= cfg_data;
                        scale_pend_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (scale_pend_reg)
                scale_reg <= scale_next;
            if (off_pend_reg)
            begin
                off_col_reg <= off_col_next;
                off_row_reg <= off_row_next;
            end
        end
    end

    assign scale      = scale_reg;
    assign offset_col = off_col_reg;
    assign offset_row = off_row_reg;
    assign busy       = scale_pend_reg | off_pend_reg;

endmodule
`default_nettype wire

### rtl/inub_ctrl.sv
`default_nettype none
module inub_ctrl import inub_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         cfg_busy,
    input  wire inub_status_t status,
    output logic              in_ready,
    output inub_cmd_t         cmd
);
    inub_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = !cfg_busy;
                cmd.accept = in_valid && !cfg_busy;
                if (cmd.accept)
                    state_next = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.row_init = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_write)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/inub_dp.sv
`default_nettype none
module inub_dp import inub_pkg::*; #(
    parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
    parameter int MAX_SCALE  = MAX_SCALE_DEF,
    parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire inub_cmd_t                    cmd,
    output inub_status_t                      status,
    input  wire logic [PixW-1:0]              pixel_value,
    input  wire logic [RegW-1:0]              eff_w,
    input  wire logic [RegW-1:0]              eff_h,
    input  wire logic [$clog2(MAX_SCALE+1)-1:0] scale,
    input  wire logic [RegW-1:0]              offset_col,
    input  wire logic [RegW-1:0]              offset_row,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [IdxW-1:0]                   dest_index,
    output logic [PixW-1:0]                   dest_pixel,
    output logic                              write_valid,
    output logic                              last_of_block,
    output logic                              last_of_frame
);
    localparam int ScaleW = $clog2(MAX_SCALE + 1);
    localparam int ColW   = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int RowW   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int MaxSrc = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int CoordW = $clog2(MAX_SCREEN + MaxSrc * MAX_SCALE + 1);
    localparam int ProdW  = CoordW + RegW;

    logic [ColW-1:0]   pos_col_reg;
    logic [RowW-1:0]   pos_row_reg;
    logic [PixW-1:0]   pix_reg;
    logic              frame_end_reg;
    logic [CoordW-1:0] base_x_reg, base_y_reg, x_reg, y_reg;
    logic [ScaleW-1:0] rx_reg, ry_reg;
    logic [IdxW-1:0]   row_addr_reg;
    logic [ProdW-1:0]  row_prod;

    logic              out_valid_reg;
    logic [IdxW-1:0]   out_index_reg;
    logic [PixW-1:0]   out_pixel_reg;
    logic              out_ok_reg, out_lob_reg, out_lof_reg;

    logic              on_screen, row_end, last_write, frame_end;
    logic [ScaleW-1:0] scale_m1;

    assign scale_m1   = scale - ScaleW'(1);
    assign row_end    = (rx_reg == scale_m1);
    assign last_write = row_end && (ry_reg == scale_m1);
    assign on_screen  = (x_reg < CoordW'(eff_w)) && (y_reg < CoordW'(eff_h));
    assign row_prod   = ProdW'(base_y_reg) * ProdW'(eff_w);
    assign frame_end  = (pos_col_reg == ColW'(SRC_WIDTH - 1)) &&
                        (pos_row_reg == RowW'(SRC_HEIGHT - 1));

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last_write = last_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_col_reg   <= '0;
            pos_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (pos_col_reg == ColW'(SRC_WIDTH - 1))
                begin
                    pos_col_reg <= '0;
                    if (pos_row_reg == RowW'(SRC_HEIGHT - 1))
                        pos_row_reg <= '0;
                    else
                        pos_row_reg <= pos_row_reg + RowW'(1);
                end
                else
                begin
                    pos_col_reg <= pos_col_reg + ColW'(1);
                end
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg       <= pixel_value;
            frame_end_reg <= frame_end;
            base_x_reg    <= CoordW'(offset_col) + CoordW'(pos_col_reg) * CoordW'(scale);
            base_y_reg    <= CoordW'(offset_row) + CoordW'(pos_row_reg) * CoordW'(scale);
        end
        if (cmd.row_init)
        begin
            row_addr_reg <= IdxW'(row_prod);
            x_reg        <= base_x_reg;
            y_reg        <= base_y_reg;
            rx_reg       <= '0;
            ry_reg       <= '0;
        end
        if (cmd.emit)
        begin
            out_ok_reg    <= on_screen;
            out_index_reg <= on_screen ? (row_addr_reg + IdxW'(x_reg)) : '0;
            out_pixel_reg <= pix_reg;
            out_lob_reg   <= last_write;
            out_lof_reg   <= last_write && frame_end_reg;
            if (row_end)
            begin
                rx_reg       <= '0;
                x_reg        <= base_x_reg;
                ry_reg       <= ry_reg + ScaleW'(1);
                y_reg        <= y_reg + CoordW'(1);
                row_addr_reg <= row_addr_reg + IdxW'(eff_w);
            end
            else
            begin
                rx_reg <= rx_reg + ScaleW'(1);
                x_reg  <= x_reg + CoordW'(1);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign dest_index    = out_index_reg;
    assign dest_pixel    = out_pixel_reg;
    assign write_valid   = out_ok_reg;
    assign last_of_block = out_lob_reg;
    assign last_of_frame = out_lof_reg;

endmodule
`default_nettype wire

### verif/integer_nearest_upscale_blitter_tb.sv
`timescale 1ns / 100ps

module integer_nearest_upscale_blitter_tb;
    import inub_pkg::*;

    localparam int SrcW      = SRC_WIDTH_DEF;
    localparam int SrcH      = SRC_HEIGHT_DEF;
    localparam int MaxScale  = MAX_SCALE_DEF;
    localparam int MaxScreen = MAX_SCREEN_DEF;

    localparam logic [CfgIdxW-1:0] CFG_SPARE_A = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CFG_SPARE_B = CfgIdxW'(3);

    localparam int RandomPixels  = 280;
    localparam int HoldCycles    = 400;
    localparam int SettleCycles  = 4;
    localparam int DrainCycles   = 80;
    localparam int WatchdogLimit = 5000;
    localparam int MaxPrints     = 60;

    typedef struct packed {
        logic [IdxW-1:0] index;
        logic [PixW-1:0] pixel;
        logic            on_screen;
        logic            block_end;
        logic            frame_end;
    } screen_write_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CFG_SCREEN_WIDTH;
    logic [RegW-1:0]    cfg_data = '0;

    inub_pix_if pix_ch ();
    inub_wr_if  wr_ch ();

    integer_nearest_upscale_blitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .wr        (wr_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // screen layout as the block should see it
    logic [RegW-1:0] screen_w_reg;
    logic [RegW-1:0] screen_h_reg;
    logic [8:0]      next_col;
    logic [7:0]      next_row;
    logic [3:0]      blit_scale;
    logic [11:0]     margin_x;
    logic [11:0]     margin_y;

    screen_write_t pending_writes[$];

    int unsigned mismatches;
    int unsigned pixels_taken;
    int unsigned writes_seen;
    int unsigned writes_dropped;
    int unsigned frames_done;
    int unsigned reg_writes;
    int unsigned quiet_cycles;

    bit          src_gaps;
    bit          sink_gaps;
    int unsigned sink_hold;

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int unsigned usable_dim(logic [RegW-1:0] v);
        if (v == '0) return 1;
        if (v > MaxScreen) return MaxScreen;
        return v;
    endfunction

    function automatic void derive_layout();
        int unsigned w;
        int unsigned h;
        int unsigned s;
        w = usable_dim(screen_w_reg);
        h = usable_dim(screen_h_reg);
        s = (w / SrcW < h / SrcH) ? w / SrcW : h / SrcH;
        if (s < 1) s = 1;
        if (s > MaxScale) s = MaxScale;
        blit_scale = 4'(s);
        margin_x = (w > SrcW * s) ? 12'((w - SrcW * s) / 2) : '0;
        margin_y = (h > SrcH * s) ? 12'((h - SrcH * s) / 2) : '0;
    endfunction

    function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
        if (idx == CFG_SCREEN_WIDTH) screen_w_reg = val;
        else if (idx == CFG_SCREEN_HEIGHT) screen_h_reg = val;
        else return;
        derive_layout();
    endfunction

    function automatic void expand_pixel(logic [PixW-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned x;
        int unsigned y;
        bit          at_frame_end;
        screen_write_t wr_exp;
        w = usable_dim(screen_w_reg);
        h = usable_dim(screen_h_reg);
        s = blit_scale;
        at_frame_end = (next_col == SrcW - 1) && (next_row == SrcH - 1);
        for (int unsigned ry = 0; ry < s; ry++) begin
            for (int unsigned rx = 0; rx < s; rx++) begin
                x = margin_x + next_col * s + rx;
                y = margin_y + next_row * s + ry;
                wr_exp.on_screen = (x < w) && (y < h);
                wr_exp.index     = wr_exp.on_screen ? IdxW'(y * w + x) : '0;
                wr_exp.pixel     = px;
                wr_exp.block_end = (ry == s - 1) && (rx == s - 1);
                wr_exp.frame_end = wr_exp.block_end && at_frame_end;
                pending_writes.push_back(wr_exp);
            end
        end
        if (next_col == SrcW - 1) begin
            next_col = '0;
            next_row = (next_row == SrcH - 1) ? '0 : next_row + 1'b1;
        end
        else begin
            next_col = next_col + 1'b1;
        end
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MaxPrints) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_write();
        screen_write_t got;
        screen_write_t want;
        got.index     = wr_ch.dest_index;
        got.pixel     = wr_ch.dest_pixel;
        got.on_screen = wr_ch.write_valid;
        got.block_end = wr_ch.last_of_block;
        got.frame_end = wr_ch.last_of_frame;
        writes_seen++;
        if (got.on_screen !== 1'b1) writes_dropped++;
        if (got.frame_end === 1'b1) frames_done++;
        if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("write with no request pending, index %h", got.index));
            return;
        end
        want = pending_writes.pop_front();
        if (got.index !== want.index)
            report_mismatch($sformatf("dest_index %h, want %h", got.index, want.index));
        if (got.pixel !== want.pixel)
            report_mismatch($sformatf("dest_pixel %h, want %h", got.pixel, want.pixel));
        if (got.on_screen !== want.on_screen)
            report_mismatch($sformatf("write_valid %b, want %b", got.on_screen, want.on_screen));
        if (got.block_end !== want.block_end)
            report_mismatch($sformatf("last_of_block %b, want %b", got.block_end,
                                      want.block_end));
        if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("last_of_frame %b, want %b", got.frame_end,
                                      want.frame_end));
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                expand_pixel(pix_ch.pixel_value);
                pixels_taken++;
            end
            if (wr_ch.valid && wr_ch.ready) check_write();
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WatchdogLimit) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (pix_ch.valid && pix_ch.ready) ||
                (wr_ch.valid && wr_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d writes pending",
                 $time, WatchdogLimit, pending_writes.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        wr_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold != 0) begin
                wr_ch.ready = 1'b0;
                sink_hold--;
            end
            else begin
                wr_ch.ready = !(sink_gaps && $urandom_range(99) < 8);
            end
        end
    end

    task automatic send_pixel(logic [PixW-1:0] px);
        while (src_gaps && $urandom_range(99) < 8) begin
            @(negedge clk);
            pix_ch.valid = 1'b0;
        end
        @(negedge clk);
        pix_ch.valid       = 1'b1;
        pix_ch.pixel_value = px;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
    endtask

    task automatic send_random(int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_pixel($urandom);
    endtask

    // stop offering, let every pending write come out
    task automatic drain();
        @(negedge clk);
        pix_ch.valid = 1'b0;
        while (pending_writes.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    task automatic end_config();
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_screen(logic [RegW-1:0] w, logic [RegW-1:0] h);
        drain();
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        end_config();
    endtask

    function automatic logic [RegW-1:0] extreme_dim();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return RegW'(1);
            2:       return RegW'(MaxScreen);
            3:       return RegW'(MaxScreen + 1);
            default: return '1;
        endcase
    endfunction

    task automatic test_directed();
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'h5A5A_5A5A);
        send_pixel(32'hA5A5_A5A5);
        // zero dimensions behave as one
        set_screen('0, '0);
        send_random(2);
        // oversized dimensions saturate, scale capped
        set_screen('1, '1);
        send_random(2);
        set_screen(RegW'(MaxScreen + 1), RegW'(MaxScreen));
        send_random(1);
        // height limits the scale, vertical margin exactly zero at 2560x1000
        set_screen(RegW'(2560), RegW'(1000));
        send_random(2);
        set_screen(RegW'(MaxScreen), RegW'(250));
        send_random(1);
        // tiny screen, writes fall off the right edge
        set_screen(RegW'(12), RegW'(2));
        send_random(4);
        // writes to unused indexes change nothing
        drain();
        write_reg(CFG_SPARE_A, RegW'(640));
        write_reg(CFG_SPARE_B, '1);
        end_config();
        send_random(2);
        set_screen(RegW'(SrcW), RegW'(SrcH));
        send_random(1);
        set_screen(RegW'(1), '1);
        send_random(1);
    endtask

    task automatic test_random_blits();
        int unsigned     sent;
        int unsigned     s;
        int unsigned     n;
        logic [RegW-1:0] w;
        logic [RegW-1:0] h;
        sent = 0;
        while (sent < RandomPixels) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = RegW'($urandom);
                    h = RegW'($urandom);
                end
                1, 2, 3, 4, 5: begin
                    s = $urandom_range(1, 3);
                    w = RegW'(SrcW * s + $urandom_range(0, SrcW - 1));
                    h = RegW'(SrcH * s + $urandom_range(0, SrcH - 1));
                end
                6: begin
                    s = $urandom_range(4, MaxScale);
                    w = RegW'(SrcW * s + $urandom_range(0, SrcW - 1));
                    h = RegW'(SrcH * s + $urandom_range(0, SrcH - 1));
                end
                7: begin
                    w = extreme_dim();
                    h = extreme_dim();
                end
                8: begin
                    w = RegW'($urandom_range(0, 64));
                    h = RegW'($urandom_range(0, 64));
                end
                default: begin
                    w = SCREEN_W_RESET;
                    h = SCREEN_H_RESET;
                end
            endcase
            drain();
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, RegW'($urandom));
            end
            if ($urandom_range(0, 4) != 0) write_reg(CFG_SCREEN_WIDTH, w);
            if ($urandom_range(0, 4) != 0) write_reg(CFG_SCREEN_HEIGHT, h);
            end_config();
            // some phases run with no idling on either side
            src_gaps  = ($urandom_range(0, 5) != 0);
            sink_gaps = src_gaps;
            n = $urandom_range(8, 30);
            for (int unsigned i = 0; i < n; i++) begin
                case ($urandom_range(0, 15))
                    0:       send_pixel('0);
                    1:       send_pixel('1);
                    default: send_pixel($urandom);
                endcase
            end
            sent += n;
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        set_screen(RegW'(640), RegW'(400));
        src_gaps  = 1'b0;
        sink_hold = HoldCycles;
        send_random(40);
        drain();
        src_gaps = 1'b1;
        send_random(10);
    endtask

    initial begin
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        src_gaps           = 1'b0;
        sink_gaps          = 1'b0;
        sink_hold          = 0;
        mismatches         = 0;
        pixels_taken       = 0;
        writes_seen        = 0;
        writes_dropped     = 0;
        frames_done        = 0;
        reg_writes         = 0;
        screen_w_reg       = SCREEN_W_RESET;
        screen_h_reg       = SCREEN_H_RESET;
        next_col           = '0;
        next_row           = '0;
        derive_layout();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        test_random_blits();
        test_backpressure();

        drain();
        repeat (DrainCycles) @(posedge clk);
        if (pending_writes.size() != 0)
            report_mismatch($sformatf("%0d writes never came", pending_writes.size()));
        $display("%0d pixels in, %0d writes checked (%0d off screen), %0d frame ends",
                 pixels_taken, writes_seen, writes_dropped, frames_done);
        $display("%0d reg writes; scales 1 to %0d, clamped and tiny screens, output stall, row wrap",
                 reg_writes, MaxScale);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/inub_pkg.sv
rtl/inub_pix_if.sv
rtl/inub_wr_if.sv
rtl/inub_cfg.sv
rtl/inub_ctrl.sv
rtl/inub_dp.sv
rtl/integer_nearest_upscale_blitter.sv
verif/integer_nearest_upscale_blitter_tb.sv
